### rtl/core/ttps_pkg.sv
package ttps_pkg;

   // field widths
   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 6;
   localparam int SCORE_W = 25;
   localparam int KIND_W  = 2;

   // packed stream widths
   localparam int REQ_FIELDS_W = KEY_W + DEPTH_W + SCORE_W + KIND_W + SCORE_W + SCORE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((SCORE_W + 7) / 8) * 8;

   localparam int INDEX_BITS_DEFAULT = 16;

   // bound kinds
   localparam logic [KIND_W-1:0] KIND_UPPER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   // request mode
   localparam logic MODE_PROBE = 1'b0;
   localparam logic MODE_STORE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic clear;   // write one empty slot of the clearing pass
      logic load;    // take the request word, read its slot
      logic commit;  // act on the slot read: write back or post result
   } cmd_type;

   typedef struct packed {
      logic clear_last;  // clearing pass at its final slot
      logic is_store;    // held request is a store
      logic out_blocked; // result register full and not being taken
   } status_type;

endpackage

### rtl/core/ttps_ctrl.sv
module ttps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ttps_pkg::status_type status,
   output ttps_pkg::cmd_type    cmd
);

   ttps_pkg::state_type state_ff;
   ttps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttps_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         ttps_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ttps_pkg::ST_EVAL;
            end
         end
         ttps_pkg::ST_EVAL: begin
            if (status.is_store || !status.out_blocked) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttps_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.clear  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ttps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ttps_pkg::ST_EVAL: begin
            cmd.commit = status.is_store || !status.out_blocked;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/ttps_dp.sv
module ttps_dp #(
   parameter int INDEX_BITS = ttps_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ttps_pkg::cmd_type                  cmd,
   output ttps_pkg::status_type               status,
   input  logic                               req_mode,
   input  logic [ttps_pkg::KEY_W-1:0]         req_key,
   input  logic [ttps_pkg::DEPTH_W-1:0]       req_depth,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_score,
   input  logic [ttps_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_alpha,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_beta,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic signed [ttps_pkg::SCORE_W-1:0] rsp_score
);

   localparam int TAG_BITS   = ttps_pkg::KEY_W - INDEX_BITS;
   localparam int SLOT_COUNT = 1 << INDEX_BITS;
   localparam int ENTRY_BITS = TAG_BITS + ttps_pkg::DEPTH_W + ttps_pkg::SCORE_W
                               + ttps_pkg::KIND_W;

   // slot word: tag | depth | score | kind (kind lowest)
   logic [ENTRY_BITS-1:0] mem_ff [SLOT_COUNT];
   logic [ENTRY_BITS-1:0] rd_ff;

   logic                               mode_ff;
   logic [ttps_pkg::KEY_W-1:0]         key_ff;
   logic [ttps_pkg::DEPTH_W-1:0]       depth_ff;
   logic signed [ttps_pkg::SCORE_W-1:0] score_ff;
   logic [ttps_pkg::KIND_W-1:0]        kind_ff;
   logic signed [ttps_pkg::SCORE_W-1:0] alpha_ff;
   logic signed [ttps_pkg::SCORE_W-1:0] beta_ff;

   logic [INDEX_BITS-1:0] clr_ff;
   logic [INDEX_BITS-1:0] clr_in;

   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic                               hit_ff;
   logic signed [ttps_pkg::SCORE_W-1:0] res_ff;

   logic [ttps_pkg::KIND_W-1:0]        e_kind;
   logic signed [ttps_pkg::SCORE_W-1:0] e_score;
   logic [ttps_pkg::DEPTH_W-1:0]       e_depth;
   logic [TAG_BITS-1:0]                e_tag;
   logic                               occupied;
   logic                               keep;
   logic                               match;
   logic                               hit;
   logic signed [ttps_pkg::SCORE_W-1:0] res;

   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  probe_commit;

   assign e_kind  = rd_ff[ttps_pkg::KIND_W-1:0];
   assign e_score = rd_ff[ttps_pkg::KIND_W +: ttps_pkg::SCORE_W];
   assign e_depth = rd_ff[ttps_pkg::KIND_W + ttps_pkg::SCORE_W +: ttps_pkg::DEPTH_W];
   assign e_tag   = rd_ff[ENTRY_BITS-1 -: TAG_BITS];

   assign occupied = (e_kind != ttps_pkg::KIND_EMPTY);
   assign keep     = occupied && (e_depth > depth_ff);
   assign match    = occupied && (e_tag == key_ff[ttps_pkg::KEY_W-1:INDEX_BITS])
                     && (e_depth >= depth_ff);

   always_comb begin
      hit = 1'b0;
      res = '0;
      if (match) begin
         if (e_kind == ttps_pkg::KIND_EXACT) begin
            hit = 1'b1;
            res = e_score;
         end else if (e_kind == ttps_pkg::KIND_UPPER && e_score <= alpha_ff) begin
            hit = 1'b1;
            res = alpha_ff;
         end else if (e_kind == ttps_pkg::KIND_LOWER && e_score >= beta_ff) begin
            hit = 1'b1;
            res = beta_ff;
         end
      end
   end

   // write port: clearing pass or a store that wins the slot
   always_comb begin
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = {{(ENTRY_BITS-ttps_pkg::KIND_W){1'b0}}, ttps_pkg::KIND_EMPTY};
      end else begin
         wr_en   = cmd.commit && (mode_ff == ttps_pkg::MODE_STORE) && !keep;
         wr_addr = key_ff[INDEX_BITS-1:0];
         wr_data = {key_ff[ttps_pkg::KEY_W-1:INDEX_BITS], depth_ff, score_ff, kind_ff};
      end
   end

   assign probe_commit = cmd.commit && (mode_ff == ttps_pkg::MODE_PROBE);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_ff <= mem_ff[req_key[INDEX_BITS-1:0]];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         depth_ff <= req_depth;
         score_ff <= req_score;
         kind_ff  <= req_kind;
         alpha_ff <= req_alpha;
         beta_ff  <= req_beta;
      end
      if (probe_commit) begin
         hit_ff <= hit;
         res_ff <= res;
      end
   end

   assign clr_in = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   always_comb begin
      if (probe_commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.clear_last  = &clr_ff;
   assign status.is_store    = (mode_ff == ttps_pkg::MODE_STORE);
   assign status.out_blocked = out_valid_ff && !rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_hit   = hit_ff;
   assign rsp_score = res_ff;

endmodule

### rtl/core/transposition_table_probe_store_unit.sv
// Transposition table, direct mapped, depth-preferred replacement.
//
// req_ channel: one word per probe or store. req_tuser carries the mode
// (0 probe, 1 store); req_tdata carries key, depth, score, bound kind,
// alpha and beta. The low INDEX_BITS of the key select the slot.
// rsp_ channel: one word per probe, none per store. rsp_tuser is the hit
// flag, rsp_tdata the score (stored, alpha or beta; zero on a miss).
//
// Timing: a word is taken and its slot is read into a register; in the
// evaluate state the slot word is examined and either written back (store,
// if it wins the slot) or the result is posted. A new word is not taken
// until the last one is through, set by the read-then-write use of the
// single slot memory. A probe result is registered and raised on rsp_tvalid
// after its evaluate state commits it. The result sits in an output
// register, so the next word is taken while a result waits. If the receiver
// stalls, a following probe waits in its evaluate cycle until the register
// frees; stores proceed regardless. Reset: a clearing pass marks every slot
// empty, one slot a cycle, with req_tready held low.
module transposition_table_probe_store_unit #(
   parameter int INDEX_BITS = ttps_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [63:0] key, [69:64] depth, [94:70] score, [96:95] bound_kind,
   // [121:97] alpha, [146:122] beta, rest zero
   input  logic [ttps_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [24:0] result_score, rest zero
   output logic [ttps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] hit
   output logic [0:0]                      rsp_tuser
);

   localparam int O_DEPTH = ttps_pkg::KEY_W;
   localparam int O_SCORE = O_DEPTH + ttps_pkg::DEPTH_W;
   localparam int O_KIND  = O_SCORE + ttps_pkg::SCORE_W;
   localparam int O_ALPHA = O_KIND + ttps_pkg::KIND_W;
   localparam int O_BETA  = O_ALPHA + ttps_pkg::SCORE_W;

   ttps_pkg::cmd_type    cmd;
   ttps_pkg::status_type status;

   logic                                rsp_hit;
   logic signed [ttps_pkg::SCORE_W-1:0] rsp_score;

   ttps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ttps_dp #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_mode  (req_tuser[0]),
      .req_key   (req_tdata[ttps_pkg::KEY_W-1:0]),
      .req_depth (req_tdata[O_DEPTH +: ttps_pkg::DEPTH_W]),
      .req_score (req_tdata[O_SCORE +: ttps_pkg::SCORE_W]),
      .req_kind  (req_tdata[O_KIND +: ttps_pkg::KIND_W]),
      .req_alpha (req_tdata[O_ALPHA +: ttps_pkg::SCORE_W]),
      .req_beta  (req_tdata[O_BETA +: ttps_pkg::SCORE_W]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_hit   (rsp_hit),
      .rsp_score (rsp_score)
   );

   assign rsp_tuser = rsp_hit;
   assign rsp_tdata = {{(ttps_pkg::RSP_DATA_W-ttps_pkg::SCORE_W){1'b0}}, rsp_score};

   // no back-to-back acceptance: each word holds the slot for its evaluate cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken during evaluate cycle");

   // a fresh result only ever follows the acceptance of a probe
   a_rsp_from_probe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tuser[0] == ttps_pkg::MODE_PROBE), 2))
      else $error("result without a matching probe");

   // a miss reports a zero score
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("miss with non-zero score");

endmodule
